### hw/rtl/fractional_area_average_downsampler_defines.svh
// Assertion macros for the downsampler.
// Each macro takes a label, clock, active-low reset and two expressions.
`ifndef FRACTIONAL_AREA_AVERAGE_DOWNSAMPLER_DEFINES_SVH
`define FRACTIONAL_AREA_AVERAGE_DOWNSAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define FAFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define FAFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define FAFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FAFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/fafd_pkg.sv
package fafd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int IN_W       = 32;
    localparam int OUT_W      = 32;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_IN_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LENGTH = 2'd1;

    // Flags that travel with a closed bin through the queue
    typedef struct packed {
        logic last;
        logic err;
    } t_bin_flags;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

### hw/rtl/fafd_fifo.sv
module fafd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

### hw/rtl/fafd_front.sv
module fafd_front #(
    parameter int MAX_LENGTH  = 65536,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [fafd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fafd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_push,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  logic                                 i_q_space,
    output logic                                 o_full,
    output logic [$clog2(MAX_LENGTH+1)-1:0]      o_lin,
    output logic                                 o_q_push,
    output logic [((SAMPLE_BITS + $clog2(MAX_LENGTH+1) <= 64) ?
                   SAMPLE_BITS + $clog2(MAX_LENGTH+1) : 64)-1:0] o_q_sum,
    output fafd_pkg::t_bin_flags                 o_q_flags
);

    import fafd_pkg::*;

    localparam int LW    = $clog2(MAX_LENGTH + 1);
    localparam int PW    = SAMPLE_BITS + LW;
    localparam int SUM_W = (PW <= 64) ? PW : 64;
    localparam int CW    = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;

    typedef enum logic [1:0] {
        FK_NONE,
        FK_ACC,
        FK_BIN,
        FK_ERR
    } t_front_kind;

    // configuration
    logic [CFG_DATA_W-1:0] r_in_len;
    logic [CFG_DATA_W-1:0] r_out_len;
    logic [CW-1:0]         in_ext;
    logic [CW-1:0]         out_ext;
    logic [CW-1:0]         lin_w;
    logic [CW-1:0]         lout_w;
    logic [LW-1:0]         lin;
    logic [LW-1:0]         lout;

    // frame state
    logic [LW-1:0] r_taken;
    logic [LW-1:0] r_units;
    logic [LW-1:0] r_bins;
    logic          r_err_rep;

    // stage A: sample registered, classified
    logic              r_va;
    logic [SAMPLE_BITS-1:0] r_s;
    t_front_kind       r_kind_a;
    logic              r_first_a;
    logic              r_last_a;
    logic [LW-1:0]     r_part;

    // stage P: products registered
    logic              r_vp;
    t_front_kind       r_kind_p;
    logic              r_first_p;
    logic              r_last_p;
    logic [SUM_W-1:0]  r_prod_lout;
    logic [SUM_W-1:0]  r_prod_part;

    logic [SUM_W-1:0]  r_sum;

    logic              accept;
    logic              cfg_hit;
    logic              first;
    logic [LW-1:0]     units_cur;
    logic [LW-1:0]     bins_cur;
    logic              errrep_cur;
    logic [LW-1:0]     bins_inc;
    logic [LW-1:0]     taken_inc;
    logic [LW-1:0]     rest;
    t_front_kind       kind;
    logic [LW-1:0]     n_taken;
    logic [LW-1:0]     n_units;
    logic [LW-1:0]     n_bins;
    logic              n_err_rep;
    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  sum_close;

    // zero acts as one, anything above the limit clamps to it
    assign in_ext  = CW'(r_in_len);
    assign out_ext = CW'(r_out_len);
    assign lin_w   = (in_ext == '0) ? CW'(1) :
                     (in_ext > CW'(MAX_LENGTH)) ? CW'(MAX_LENGTH) : in_ext;
    assign lout_w  = (out_ext == '0) ? CW'(1) :
                     (out_ext > CW'(MAX_LENGTH)) ? CW'(MAX_LENGTH) : out_ext;
    assign lin     = lin_w[LW-1:0];
    assign lout    = lout_w[LW-1:0];

    assign cfg_hit = i_cfg_valid &&
                     (i_cfg_index == REG_IN_LENGTH || i_cfg_index == REG_OUT_LENGTH);

    // one sample in flight at a time
    assign o_full = r_va || r_vp || !i_q_space;
    assign accept = i_push && !o_full;

    always_comb begin
        first      = (r_taken == '0);
        units_cur  = first ? lin : r_units;
        bins_cur   = first ? '0 : r_bins;
        errrep_cur = first ? 1'b0 : r_err_rep;
        bins_inc   = bins_cur + LW'(1);
        taken_inc  = r_taken + LW'(1);
        rest       = lout - units_cur;
        n_taken    = (taken_inc >= lin) ? '0 : taken_inc;
        n_units    = units_cur;
        n_bins     = bins_cur;
        n_err_rep  = errrep_cur;
        if (lout > lin) begin
            kind      = errrep_cur ? FK_NONE : FK_ERR;
            n_err_rep = 1'b1;
        end else if (lout < units_cur) begin
            kind    = FK_ACC;
            n_units = units_cur - lout;
        end else begin
            kind    = FK_BIN;
            n_bins  = bins_inc;
            n_units = lin - rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_len  <= CFG_DATA_W'(1);
            r_out_len <= CFG_DATA_W'(1);
            r_taken   <= '0;
            r_va      <= 1'b0;
            r_vp      <= 1'b0;
        end else begin
            if (cfg_hit) begin
                if (i_cfg_index == REG_IN_LENGTH) begin
                    r_in_len <= i_cfg_data;
                end else begin
                    r_out_len <= i_cfg_data;
                end
                r_taken <= '0;
            end else if (accept) begin
                r_taken <= n_taken;
            end
            r_va <= accept;
            r_vp <= r_va;
        end
    end

    // counters and payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_units   <= n_units;
            r_bins    <= n_bins;
            r_err_rep <= n_err_rep;
            r_s       <= i_sample;
            r_kind_a  <= kind;
            r_first_a <= first;
            r_last_a  <= (bins_inc >= lout);
            r_part    <= units_cur;
        end
        if (r_va) begin
            r_kind_p    <= r_kind_a;
            r_first_p   <= r_first_a;
            r_last_p    <= r_last_a;
            r_prod_lout <= SUM_W'(PW'(r_s) * PW'(lout));
            r_prod_part <= SUM_W'(PW'(r_s) * PW'(r_part));
        end
        if (r_vp) begin
            case (r_kind_p)
                FK_ACC:  r_sum <= base + r_prod_lout;
                FK_BIN:  r_sum <= r_prod_lout - r_prod_part;
                default: r_sum <= r_sum;
            endcase
        end
    end

    // a new frame starts the sum from zero
    assign base      = r_first_p ? '0 : r_sum;
    assign sum_close = base + r_prod_part;

    assign o_lin          = lin;
    assign o_q_push       = r_vp && (r_kind_p == FK_BIN || r_kind_p == FK_ERR);
    assign o_q_sum        = (r_kind_p == FK_ERR) ? '0 : sum_close;
    assign o_q_flags.last = (r_kind_p == FK_ERR) ? 1'b1 : r_last_p;
    assign o_q_flags.err  = (r_kind_p == FK_ERR);

endmodule

### hw/rtl/fafd_back.sv
module fafd_back #(
    parameter int MAX_LENGTH  = 65536,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [$clog2(MAX_LENGTH+1)-1:0]      i_lin,
    input  logic                                 i_q_valid,
    input  logic [((SAMPLE_BITS + $clog2(MAX_LENGTH+1) <= 64) ?
                   SAMPLE_BITS + $clog2(MAX_LENGTH+1) : 64)-1:0] i_q_sum,
    input  fafd_pkg::t_bin_flags                 i_q_flags,
    output logic                                 o_q_pop,
    input  logic                                 i_pop,
    output logic                                 o_empty,
    output logic [fafd_pkg::OUT_W-1:0]           o_bin_value,
    output logic                                 o_last_bin,
    output logic                                 o_length_error
);

    import fafd_pkg::*;

    localparam int LW        = $clog2(MAX_LENGTH + 1);
    localparam int PW        = SAMPLE_BITS + LW;
    localparam int SUM_W     = (PW <= 64) ? PW : 64;
    // without wrap the quotient fits the sample width
    localparam int DIV_STEPS = (PW <= 64) ? SAMPLE_BITS : 64;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [LW-1:0]        r_rem;
    logic [DIV_STEPS-1:0] r_dq;
    logic [CNT_W-1:0]     r_cnt;
    t_bin_flags           r_flags;

    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_value;
    logic                 r_out_last;
    logic                 r_out_err;

    logic [LW:0]          trial;
    logic [LW:0]          diff;
    logic                 ge;
    logic [LW-1:0]        n_rem;
    logic                 out_load;
    logic                 step_last;

    // restoring division, one quotient bit per cycle
    assign trial     = {r_rem, r_dq[DIV_STEPS-1]};
    assign diff      = trial - {1'b0, i_lin};
    assign ge        = (trial >= {1'b0, i_lin});
    assign n_rem     = ge ? diff[LW-1:0] : trial[LW-1:0];
    assign step_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_flags.err ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV: begin
                if (step_last) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_load) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = (r_state == BK_IDLE) && i_q_valid;
        out_load = (r_state == BK_DONE) && (!r_out_valid || i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_flags <= i_q_flags;
            r_rem   <= LW'(i_q_sum >> DIV_STEPS);
            r_dq    <= i_q_flags.err ? '0 : i_q_sum[DIV_STEPS-1:0];
            r_cnt   <= '0;
        end else if (r_state == BK_DIV) begin
            r_rem <= n_rem;
            r_dq  <= {r_dq[DIV_STEPS-2:0], ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (out_load) begin
            r_out_value <= OUT_W'(r_dq);
            r_out_last  <= r_flags.last;
            r_out_err   <= r_flags.err;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_bin_value    = r_out_value;
    assign o_last_bin     = r_out_last;
    assign o_length_error = r_out_err;

endmodule

### hw/rtl/fractional_area_average_downsampler.sv
// Fractional area-averaging downsampler.
// Input: one unsigned Q8.24 sample per item on i_sample, taken when i_push is
// high and o_full is low. A frame is in_length samples; it yields out_length
// bins, each the overlap-weighted sum of its samples divided by in_length.
// Output: a queue interface. While o_empty is low the oldest bin sits on
// o_bin_value / o_last_bin / o_length_error; i_pop takes it. If out_length
// exceeds in_length the frame yields a single item with length_error and
// last_bin set and a value of zero.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index (0 = in_length,
// 1 = out_length) and i_cfg_data; o_cfg_ready is always high. A write
// restarts the frame. Other indexes are ignored.
// Flow: the front holds one sample at a time while it is accepted,
// multiplied and accumulated. Closed bins pass a 4-entry queue to a
// shift-subtract divider that takes one bin at a time, one quotient bit a
// cycle. A finished bin waits in the divider's done state until the output
// register is free, and is then registered there for the receiver.
// A stalled receiver holds the output register; the divider finishes into
// its done state, the queue fills and then o_full holds off new samples.
// Reset (synchronous, active low) sets both lengths to 1 and empties all
// stages.
`include "fractional_area_average_downsampler_defines.svh"

module fractional_area_average_downsampler #(
    parameter int MAX_LENGTH  = 65536,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fafd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fafd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [fafd_pkg::IN_W-1:0]         i_sample,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic [fafd_pkg::OUT_W-1:0]        o_bin_value,
    output logic                              o_last_bin,
    output logic                              o_length_error
);

    import fafd_pkg::*;

    localparam int LW      = $clog2(MAX_LENGTH + 1);
    localparam int PW      = SAMPLE_BITS + LW;
    localparam int SUM_W   = (PW <= 64) ? PW : 64;
    localparam int Q_DEPTH = 4;
    localparam int Q_W     = SUM_W + $bits(t_bin_flags);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    logic [SAMPLE_BITS-1:0] sample_s;
    logic [LW-1:0]          lin;
    logic                   q_push;
    logic                   q_pop;
    logic [SUM_W-1:0]       q_sum_in;
    t_bin_flags             q_flags_in;
    logic [Q_W-1:0]         q_rd;
    logic [QC_W-1:0]        q_count;
    logic                   q_space;
    logic [SUM_W-1:0]       q_sum_out;
    t_bin_flags             q_flags_out;

    assign o_cfg_ready = 1'b1;
    // only the low SAMPLE_BITS bits take part
    assign sample_s    = SAMPLE_BITS'(i_sample);
    assign q_space     = (q_count < QC_W'(Q_DEPTH));

    fafd_front #(
        .MAX_LENGTH  (MAX_LENGTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_sample    (sample_s),
        .i_q_space   (q_space),
        .o_full      (o_full),
        .o_lin       (lin),
        .o_q_push    (q_push),
        .o_q_sum     (q_sum_in),
        .o_q_flags   (q_flags_in)
    );

    fafd_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({q_sum_in, q_flags_in}),
        .i_pop   (q_pop),
        .o_data  (q_rd),
        .o_count (q_count)
    );

    assign q_sum_out   = q_rd[Q_W-1:$bits(t_bin_flags)];
    assign q_flags_out = t_bin_flags'(q_rd[$bits(t_bin_flags)-1:0]);

    fafd_back #(
        .MAX_LENGTH  (MAX_LENGTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_lin          (lin),
        .i_q_valid      (q_count != '0),
        .i_q_sum        (q_sum_out),
        .i_q_flags      (q_flags_out),
        .o_q_pop        (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_bin_value    (o_bin_value),
        .o_last_bin     (o_last_bin),
        .o_length_error (o_length_error)
    );

    // error items are always last and carry zero
    `FAFD_ASSERT_IMPLIES(a_err_item_form, i_clk, i_rst_n,
        !o_empty && o_length_error, o_last_bin && o_bin_value == '0)
    // the queue never takes an item without room
    `FAFD_ASSERT_IMPLIES(a_queue_room, i_clk, i_rst_n,
        q_push, q_count < QC_W'(Q_DEPTH) || q_pop)
    // one sample in flight in the front
    `FAFD_ASSERT_NEXT(a_front_busy, i_clk, i_rst_n, i_push && !o_full, o_full)

endmodule

### tb/fractional_area_average_downsampler_tb.sv
`timescale 1ns / 1ps

module fractional_area_average_downsampler_tb;
    import fafd_pkg::*;

    localparam int MAX_LEN        = 65536;
    localparam int RESET_CYCLES   = 11;
    localparam int GAP_MAX        = 16;
    localparam int RANDOM_ITEMS   = 400;
    // margin for a bin to pass the front, the queue, the divider and the output after its closing sample
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 5000;

    // indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        STIM_SAMPLE,
        STIM_CFG,
        STIM_DRAIN
    } t_stim_kind;

    typedef struct {
        t_stim_kind             kind;
        logic [IN_W-1:0]        sample;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
    } t_stim;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             last;
        logic             err;
    } t_bin_item;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_push = 1'b0;
    logic                   o_full;
    logic [IN_W-1:0]        i_sample = '0;
    logic                   o_empty;
    logic                   i_pop = 1'b0;
    logic [OUT_W-1:0]       o_bin_value;
    logic                   o_last_bin;
    logic                   o_length_error;

    fractional_area_average_downsampler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_sample       (i_sample),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_bin_value    (o_bin_value),
        .o_last_bin     (o_last_bin),
        .o_length_error (o_length_error)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bin predictor: register copies and frame state
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] cfg_in_len;
    logic [CFG_DATA_W-1:0] cfg_out_len;
    logic [63:0]           area_sum;       // sample * overlap units of the open bin
    logic [16:0]           units_missing;  // units still to fill the open bin
    logic [16:0]           frame_samples;
    logic [16:0]           frame_bins;
    bit                    err_given;

    t_bin_item pending_bins[$];   // predicted bins, oldest first
    t_stim     stim_q[$];         // items still to drive

    int errors = 0;

    // 0 acts as 1, anything past the maximum is clipped
    function automatic logic [16:0] clamp_length(input logic [CFG_DATA_W-1:0] v);
        if (v == '0)
            return 17'd1;
        if (v > 17'(MAX_LEN))
            return 17'(MAX_LEN);
        return v;
    endfunction

    task automatic open_frame();
        area_sum      = '0;
        units_missing = clamp_length(cfg_in_len);
        frame_samples = '0;
        frame_bins    = '0;
        err_given     = 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_IN_LENGTH) begin
            cfg_in_len = data;
            open_frame();
        end else if (idx == REG_OUT_LENGTH) begin
            cfg_out_len = data;
            open_frame();
        end
        // spare indexes leave the frame alone
    endtask

    // Each sample is out_length units wide, each bin in_length units wide.
    task automatic take_sample(input logic [IN_W-1:0] s);
        logic [16:0] lin;
        logic [16:0] lout;
        logic [16:0] part;
        logic [16:0] rest;
        t_bin_item   b;
        lin  = clamp_length(cfg_in_len);
        lout = clamp_length(cfg_out_len);
        if (frame_samples == '0)
            open_frame();
        if (lout > lin) begin
            // upsampling is refused: one flagged item per frame
            if (!err_given) begin
                err_given = 1'b1;
                b.value   = '0;
                b.last    = 1'b1;
                b.err     = 1'b1;
                pending_bins.push_back(b);
            end
        end else if (lout < units_missing) begin
            area_sum      += 64'(s) * 64'(lout);
            units_missing -= lout;
        end else begin
            // sample closes the bin; its remainder opens the next one
            part        = units_missing;
            rest        = lout - part;
            area_sum   += 64'(s) * 64'(part);
            frame_bins += 17'd1;
            b.value     = OUT_W'(area_sum / 64'(lin));
            b.last      = (frame_bins >= lout);
            b.err       = 1'b0;
            pending_bins.push_back(b);
            area_sum      = 64'(s) * 64'(rest);
            units_missing = lin - rest;
        end
        frame_samples += 17'd1;
        if (frame_samples >= lin)
            frame_samples = '0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus list helpers
    // ------------------------------------------------------------------
    task automatic add_sample(input logic [IN_W-1:0] s);
        t_stim t;
        t.kind   = STIM_SAMPLE;
        t.sample = s;
        t.index  = '0;
        t.data   = '0;
        stim_q.push_back(t);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_stim t;
        t.kind   = STIM_CFG;
        t.sample = '0;
        t.index  = idx;
        t.data   = data;
        stim_q.push_back(t);
    endtask

    // sender holds off until every predicted bin has been taken
    task automatic add_drain();
        t_stim t;
        t.kind   = STIM_DRAIN;
        t.sample = '0;
        t.index  = '0;
        t.data   = '0;
        stim_q.push_back(t);
    endtask

    function automatic logic [IN_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return IN_W'($urandom);
        endcase
    endfunction

    // n random samples, now and then a spare-index write or a full drain
    task automatic add_run(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0)
                add_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                        CFG_DATA_W'($urandom));
            else if ($urandom_range(0, 29) == 0)
                add_drain();
            add_sample(rand_sample());
        end
    endtask

    task automatic add_lengths(input logic [CFG_DATA_W-1:0] lin,
                               input logic [CFG_DATA_W-1:0] lout);
        if ($urandom_range(0, 1)) begin
            add_cfg(REG_IN_LENGTH, lin);
            add_cfg(REG_OUT_LENGTH, lout);
        end else begin
            add_cfg(REG_OUT_LENGTH, lout);
            add_cfg(REG_IN_LENGTH, lin);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one item from stim_q at a time
    // ------------------------------------------------------------------
    t_stim       cur;
    bit          busy;
    int unsigned hold;
    bit          send_burst;

    always @(posedge i_clk) begin
        logic nxt_push;
        logic nxt_cfg;
        if (!i_rst_n) begin
            cfg_in_len  = 17'd1;
            cfg_out_len = 17'd1;
            open_frame();
            busy        = 1'b0;
            hold        = 0;
            send_burst  = 1'b0;
            i_push      <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nxt_push = i_push;
            nxt_cfg  = i_cfg_valid;
            if (i_push && !o_full) begin
                take_sample(i_sample);
                nxt_push = 1'b0;
                busy     = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
                nxt_cfg = 1'b0;
                busy    = 1'b0;
            end
            if (!busy && stim_q.size() != 0) begin
                cur  = stim_q.pop_front();
                busy = 1'b1;
                if ($urandom_range(0, 31) == 0)
                    send_burst = !send_burst;
                if (cur.kind == STIM_SAMPLE)
                    hold = send_burst ? 0 : $urandom_range(0, GAP_MAX);
                else
                    hold = SETTLE_CYCLES;
            end
            if (busy && !nxt_push && !nxt_cfg) begin
                // register writes and drains wait for an idle block
                if (cur.kind != STIM_SAMPLE && pending_bins.size() != 0) begin
                    hold = SETTLE_CYCLES;
                end else if (hold > 0) begin
                    hold--;
                end else begin
                    case (cur.kind)
                        STIM_SAMPLE: begin
                            nxt_push = 1'b1;
                            i_sample <= cur.sample;
                        end
                        STIM_CFG: begin
                            nxt_cfg     = 1'b1;
                            i_cfg_index <= cur.index;
                            i_cfg_data  <= cur.data;
                        end
                        default: begin
                            busy = 1'b0;
                        end
                    endcase
                end
            end
            i_push      <= nxt_push;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random pop stalls, compare against the oldest prediction
    // ------------------------------------------------------------------
    int unsigned stall;
    bit          take_burst;

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_bin_item want;
        if (!i_rst_n) begin
            stall      = 0;
            take_burst = 1'b0;
            i_pop      <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (pending_bins.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual %h/%b/%b",
                             $time, o_bin_value, o_last_bin, o_length_error);
                end else begin
                    want = pending_bins.pop_front();
                    check_field("bin_value", want.value, o_bin_value);
                    check_field("last_bin", OUT_W'(want.last), OUT_W'(o_last_bin));
                    check_field("length_error", OUT_W'(want.err), OUT_W'(o_length_error));
                end
                if ($urandom_range(0, 31) == 0)
                    take_burst = !take_burst;
                stall = take_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall > 0) begin
                stall--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no handshake of any kind for too long
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned lin;
        int unsigned lout;
        int unsigned total;
        int unsigned pick;

        // equal lengths given as zero, so both act as 1: each bin is its sample
        add_cfg(REG_IN_LENGTH, '0);
        add_cfg(REG_OUT_LENGTH, '0);
        add_sample('0);
        add_sample('1);
        add_sample(32'h5555_5555);
        add_sample(32'hAAAA_AAAA);

        // 5 -> 3: samples straddle bin edges; a spare-index write lands mid-frame
        add_cfg(REG_IN_LENGTH, 17'd5);
        add_cfg(REG_OUT_LENGTH, 17'd3);
        add_sample('1);
        add_sample('1);
        add_cfg(REG_SPARE_A, '1);
        add_sample(32'h0000_0001);
        add_drain();
        add_sample(32'h8000_0000);
        add_cfg(REG_SPARE_B, '0);
        add_sample('1);

        // output longer than input: one error item per 2-sample frame
        add_cfg(REG_IN_LENGTH, 17'd2);
        add_cfg(REG_OUT_LENGTH, 17'd3);
        add_sample('1);
        add_sample(32'h1234_5678);
        add_sample('0);
        add_sample('1);

        // over-range lengths clip to the maximum, frame abandoned part way
        add_cfg(REG_IN_LENGTH, '1);
        add_cfg(REG_OUT_LENGTH, '1);
        add_sample('1);
        add_sample('0);
        add_sample(32'hDEAD_BEEF);
        add_sample('1);

        // widest lengths, one unit short: a bin closes on nearly every sample
        add_cfg(REG_IN_LENGTH, 17'(MAX_LEN));
        add_cfg(REG_OUT_LENGTH, 17'(MAX_LEN - 1));
        add_sample('1);
        add_sample('1);
        add_sample('1);
        add_sample('1);

        total = 0;
        while (total < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // small frames, completed and sometimes followed by a partial one
                lin  = $urandom_range(1, 12);
                lout = $urandom_range(1, lin);
                add_lengths(17'(lin), 17'(lout));
                lin  = lin * $urandom_range(1, 3) + $urandom_range(0, 1) * $urandom_range(0, lin);
                add_run(lin);
                total += lin;
            end else if (pick < 72) begin
                // too many bins asked for
                lin  = $urandom_range(1, 8);
                lout = lin + $urandom_range(1, 8);
                add_lengths(17'(lin), 17'(lout));
                lin  = $urandom_range(1, 2 * lin + 1);
                add_run(lin);
                total += lin;
            end else if (pick < 80) begin
                // out-of-range encodings
                if ($urandom_range(0, 1))
                    add_lengths('0, 17'($urandom_range(0, 1)));
                else
                    add_lengths(17'($urandom_range(MAX_LEN + 1, 131071)),
                                $urandom_range(0, 1) ? '0 : 17'($urandom_range(MAX_LEN, 131071)));
                lin = $urandom_range(1, 6);
                add_run(lin);
                total += lin;
            end else if (pick < 90) begin
                // large frames cut short; bins close nearly every sample
                lin  = $urandom_range(1000, MAX_LEN);
                lout = lin - $urandom_range(0, 3);
                add_lengths(17'(lin), 17'(lout));
                lin  = $urandom_range(4, 16);
                add_run(lin);
                total += lin;
            end else begin
                // medium frames, bins sparser
                lin  = $urandom_range(13, 64);
                lout = $urandom_range(1, lin);
                add_lengths(17'(lin), 17'(lout));
                add_run(lin);
                total += lin;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all items accepted and every predicted bin taken
        @(posedge i_clk);
        while (stim_q.size() != 0 || busy || i_push || i_cfg_valid || pending_bins.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending_bins.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### fractional_area_average_downsampler.f
+incdir+hw/rtl
hw/rtl/fafd_pkg.sv
hw/rtl/fafd_fifo.sv
hw/rtl/fafd_front.sv
hw/rtl/fafd_back.sv
hw/rtl/fractional_area_average_downsampler.sv
tb/fractional_area_average_downsampler_tb.sv
